// ===== src/assert_macros.svh =====
// Assertion macros used by the checker of the pop-order sorter.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, reset included.
`define SDPOS_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

// Checked only while out of reset.
`define SDPOS_ASSERT_RUN(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

`endif

// ===== src/sdpos_pkg.sv =====
// Package of the square-doubling pop-order sorter: widths, codes, types, helpers.
// No dependencies; the other source files, apart from assert_macros.svh, use it by scoped names.
package sdpos_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 16;
    localparam int POS_W         = 6;
    localparam int THR_W         = 32;
    localparam int SQ_W          = 32;
    localparam int LIMIT_W       = 6;
    localparam int ROUND_CAP     = 32;
    localparam int ROUND_W       = 5;
    localparam int TAG_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [LIMIT_W-1:0] ROUND_CAP_L = LIMIT_W'(ROUND_CAP);
    localparam logic [THR_W-1:0]   THR_RESET   = 32'd65535;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POP_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_LIMIT   = 1'b1;

    // Tag: top bit set means the value never pops (zero), else low bits give the round.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic               present;
        logic               last;
        logic               dropped;
    } result_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

    // Number of bits up to and including the highest set bit.
    function automatic logic [LIMIT_W-1:0] bit_len(input logic [SQ_W-1:0] x);
        logic [LIMIT_W-1:0] n;
        n = '0;
        for (int b = 0; b < SQ_W; b++) begin
            if (x[b]) begin
                n = LIMIT_W'(b + 1);
            end
        end
        return n;
    endfunction

    // Number of consecutive set bits starting from bit 0.
    function automatic logic [LIMIT_W-1:0] trailing_ones(input logic [ROUND_CAP-1:0] x);
        logic [LIMIT_W-1:0] n;
        n = ROUND_CAP_L;
        for (int b = ROUND_CAP - 1; b >= 0; b--) begin
            if (!x[b]) begin
                n = LIMIT_W'(b);
            end
        end
        return n;
    endfunction

endpackage

// ===== src/sdpos_if.sv =====
// Channel interfaces of the pop-order sorter: input items and results.
// Depends on sdpos_pkg for field widths.
interface sdpos_item_if;
    logic                            valid;
    logic                            ready;
    logic [sdpos_pkg::VALUE_W-1:0]   item_value;
    logic                            batch_end;

    modport source (output valid, item_value, batch_end, input ready);
    modport sink   (input valid, item_value, batch_end, output ready);
endinterface

interface sdpos_result_if;
    logic                            valid;
    logic                            ready;
    logic [sdpos_pkg::VALUE_W-1:0]   out_value;
    logic [sdpos_pkg::POS_W-1:0]     out_position;
    logic                            out_valid;
    logic                            out_last;
    logic                            out_dropped;

    modport source (output valid, out_value, out_position, out_valid, out_last, out_dropped,
                    input ready);
    modport sink   (input valid, out_value, out_position, out_valid, out_last, out_dropped,
                    output ready);
endinterface

// ===== src/sdpos_front.sv =====
// Front end of the pop-order sorter: squares each value and works out its pop round.
// Depends on sdpos_pkg.
module sdpos_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sdpos_pkg::VALUE_W-1:0]     in_value,
    input  logic                              in_end,
    input  logic [sdpos_pkg::THR_W-1:0]       threshold,
    output logic                              push,
    output sdpos_pkg::item_t                  push_item,
    input  logic                              q_full
);

    logic                                s1_valid_reg;
    logic [sdpos_pkg::VALUE_W-1:0]       s1_value_reg;
    logic                                s1_end_reg;
    logic                                s2_valid_reg;
    logic [sdpos_pkg::VALUE_W-1:0]       s2_value_reg;
    logic                                s2_end_reg;
    logic [sdpos_pkg::SQ_W-1:0]          s2_sq_reg;
    logic                                s3_valid_reg;
    logic [sdpos_pkg::VALUE_W-1:0]       s3_value_reg;
    logic                                s3_end_reg;
    logic [sdpos_pkg::SQ_W-1:0]          s3_sq_reg;
    logic [sdpos_pkg::LIMIT_W-1:0]       s3_k0_reg;
    logic                                s3_nz_reg;

    logic                                adv;
    logic [sdpos_pkg::SQ_W-1:0]          sq;
    logic [sdpos_pkg::LIMIT_W-1:0]       len_sq;
    logic [sdpos_pkg::LIMIT_W-1:0]       len_thr;
    logic [sdpos_pkg::LIMIT_W-1:0]       k0;
    logic [sdpos_pkg::THR_W-1:0]         thr_shift;
    logic                                hit;
    logic [sdpos_pkg::LIMIT_W-1:0]       shift_k;
    logic [sdpos_pkg::LIMIT_W-1:0]       round_full;

    // Advance the whole pipe unless the last stage is blocked by a full queue.
    assign adv      = !s3_valid_reg || !q_full;
    assign in_ready = adv;
    assign push     = s3_valid_reg && !q_full;

    assign sq = sdpos_pkg::SQ_W'(s1_value_reg) * sdpos_pkg::SQ_W'(s1_value_reg);

    // sq << k > T holds exactly when sq > T >> k; bit lengths narrow k to two choices.
    assign len_sq  = sdpos_pkg::bit_len(s2_sq_reg);
    assign len_thr = sdpos_pkg::bit_len(threshold);
    assign k0      = (len_thr > len_sq) ? (len_thr - len_sq) : sdpos_pkg::LIMIT_W'(1);

    assign thr_shift  = threshold >> s3_k0_reg;
    assign hit        = s3_sq_reg > thr_shift;
    assign shift_k    = hit ? s3_k0_reg : (s3_k0_reg + 1'b1);
    assign round_full = shift_k - 1'b1;

    always_comb
    begin
        push_item.value = s3_value_reg;
        push_item.last  = s3_end_reg;
        if (s3_nz_reg)
        begin
            push_item.tag = {1'b0, round_full[sdpos_pkg::ROUND_W-1:0]};
        end
        else
        begin
            push_item.tag = {1'b1, {sdpos_pkg::ROUND_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_value_reg <= in_value;
            s1_end_reg   <= in_end;
            s2_value_reg <= s1_value_reg;
            s2_end_reg   <= s1_end_reg;
            s2_sq_reg    <= sq;
            s3_value_reg <= s2_value_reg;
            s3_end_reg   <= s2_end_reg;
            s3_sq_reg    <= s2_sq_reg;
            s3_k0_reg    <= k0;
            s3_nz_reg    <= (s2_sq_reg != '0);
        end
    end

endmodule

// ===== src/sdpos_queue.sv =====
// Short queue of classified items between the front and back of the pop-order sorter.
// Depends on sdpos_pkg.
module sdpos_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sdpos_pkg::item_t   push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output sdpos_pkg::item_t   pop_item
);

    localparam int PTR_W = $clog2(sdpos_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sdpos_pkg::QUEUE_DEPTH + 1);

    sdpos_pkg::item_t   slot_reg [sdpos_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(sdpos_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/sdpos_back.sv =====
// Back end of the pop-order sorter: stores the batch, then sweeps it round by round.
// Depends on sdpos_pkg.
module sdpos_back
#(
    parameter int MAX_ITEMS = sdpos_pkg::MAX_ITEMS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  sdpos_pkg::item_t                q_item,
    output logic                            q_pop,
    input  logic [sdpos_pkg::LIMIT_W-1:0]   round_limit,
    output logic                            res_valid,
    input  logic                            res_ready,
    output sdpos_pkg::result_t              res
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    sdpos_pkg::entry_t                  mem [MAX_ITEMS];
    sdpos_pkg::entry_t                  rd_data_reg;

    sdpos_pkg::back_state_t             state_reg;
    sdpos_pkg::back_state_t             state_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               overflow_reg;
    logic                               overflow_next;
    logic [sdpos_pkg::ROUND_CAP-1:0]    seen_reg;
    logic [sdpos_pkg::ROUND_CAP-1:0]    seen_next;
    logic [sdpos_pkg::LIMIT_W-1:0]      rounds_reg;
    logic [sdpos_pkg::LIMIT_W-1:0]      rounds_next;
    logic [sdpos_pkg::ROUND_W-1:0]      round_reg;
    logic [sdpos_pkg::ROUND_W-1:0]      round_next;
    logic [ADDR_W-1:0]                  idx_reg;
    logic [ADDR_W-1:0]                  idx_next;
    logic                               hold_valid_reg;
    logic                               hold_valid_next;
    logic [sdpos_pkg::VALUE_W-1:0]      hold_value_reg;
    logic [sdpos_pkg::VALUE_W-1:0]      hold_value_next;
    logic [sdpos_pkg::POS_W-1:0]        pos_reg;
    logic [sdpos_pkg::POS_W-1:0]        pos_next;
    logic                               res_full_reg;
    sdpos_pkg::result_t                 res_reg;

    logic                               mem_we;
    logic                               rd_en;
    logic [ADDR_W-1:0]                  rd_addr;
    logic                               push_res;
    sdpos_pkg::result_t                 res_data;
    logic                               out_free;
    logic [sdpos_pkg::LIMIT_W-1:0]      limit_eff;
    logic [sdpos_pkg::LIMIT_W-1:0]      trail;
    logic                               match;
    logic                               last_idx;
    logic                               last_round;
    logic                               consume;

    assign out_free  = !res_full_reg || res_ready;
    assign res_valid = res_full_reg;
    assign res       = res_reg;

    assign limit_eff = (round_limit > sdpos_pkg::ROUND_CAP_L) ? sdpos_pkg::ROUND_CAP_L
                                                              : round_limit;
    assign trail     = sdpos_pkg::trailing_ones(seen_reg);

    assign match      = (rd_data_reg.tag == {1'b0, round_reg});
    assign last_idx   = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign last_round = ((sdpos_pkg::LIMIT_W'(round_reg) + 1'b1) == rounds_reg);
    // Stall only when a second hit needs the held one moved out and the output is busy.
    assign consume    = !(match && hold_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdpos_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        seen_next       = seen_reg;
        rounds_next     = rounds_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        pos_next        = pos_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        push_res        = 1'b0;
        res_data        = '0;

        unique case (state_reg)
            sdpos_pkg::ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (!q_item.tag[sdpos_pkg::TAG_W-1])
                        begin
                            seen_next = seen_reg | (sdpos_pkg::ROUND_CAP'(1)
                                        << q_item.tag[sdpos_pkg::ROUND_W-1:0]);
                        end
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (q_item.last)
                    begin
                        state_next = sdpos_pkg::ST_PRIME;
                    end
                end
            end

            sdpos_pkg::ST_PRIME:
            begin
                rounds_next = (trail < limit_eff) ? trail : limit_eff;
                round_next  = '0;
                idx_next    = '0;
                if ((trail == '0) || (limit_eff == '0))
                begin
                    state_next = sdpos_pkg::ST_FLUSH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = sdpos_pkg::ST_SCAN;
                end
            end

            sdpos_pkg::ST_SCAN:
            begin
                if (consume)
                begin
                    if (match)
                    begin
                        if (hold_valid_reg)
                        begin
                            push_res          = 1'b1;
                            res_data.value    = hold_value_reg;
                            res_data.position = pos_reg;
                            res_data.present  = 1'b1;
                            res_data.last     = 1'b0;
                            res_data.dropped  = overflow_reg;
                            pos_next          = pos_reg + 1'b1;
                        end
                        hold_valid_next = 1'b1;
                        hold_value_next = rd_data_reg.value;
                    end
                    if (last_idx)
                    begin
                        idx_next = '0;
                        if (last_round)
                        begin
                            state_next = sdpos_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            round_next = round_reg + 1'b1;
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end

            sdpos_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    push_res          = 1'b1;
                    res_data.value    = hold_valid_reg ? hold_value_reg : '0;
                    res_data.position = hold_valid_reg ? pos_reg : '0;
                    res_data.present  = hold_valid_reg;
                    res_data.last     = 1'b1;
                    res_data.dropped  = overflow_reg;
                    count_next        = '0;
                    overflow_next     = 1'b0;
                    seen_next         = '0;
                    hold_valid_next   = 1'b0;
                    pos_next          = '0;
                    state_next        = sdpos_pkg::ST_LOAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            seen_reg       <= '0;
            rounds_reg     <= '0;
            round_reg      <= '0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            pos_reg        <= '0;
            res_full_reg   <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            seen_reg       <= seen_next;
            rounds_reg     <= rounds_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            pos_reg        <= pos_next;
            if (push_res)
            begin
                res_full_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_value_reg <= hold_value_next;
        if (push_res)
        begin
            res_reg <= res_data;
        end
    end

    // Batch store: one write port while loading, one registered read port while sweeping.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= '{value: q_item.value, tag: q_item.tag};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== src/square_doubling_pop_order_sorter.sv =====
// Top level of the square-doubling pop-order sorter: config registers, front, queue, back.
// Depends on sdpos_pkg, sdpos_if, sdpos_front, sdpos_queue and sdpos_back.
//
// Collects a batch of 16-bit values, one request per cycle, and on the request
// marked batch_end emits the values that pop, ordered by pop round and then by
// load order, each with its position. A value pops in the first round r for
// which (value*value) << (r+1) exceeds pop_threshold; rounds are tried from
// zero and the walk stops at the first round in which nothing pops, or at
// round_limit (capped at 32). Zeros never pop. A batch with no popped value
// yields one result with out_valid low; out_last marks the final result and
// out_dropped flags requests that arrived with MAX_ITEMS already stored.
// Timing: the front takes one request per cycle through three register stages
// (multiply, bit length, shift and compare) into a four-entry queue; the back
// stores one item per cycle. At batch end the back sets up in ST_PRIME, then
// sweeps its single-read-port store item by item once per round in ST_SCAN
// (rounds is the number of rounds that actually pop, at most 32), and closes
// the batch in ST_FLUSH; back-pressure from the sink can stall both. Input
// requests are held off only once the queue and front pipe are full during that
// sweep. The store needs no clearing pass after reset. Configuration writes take effect on the
// next edge and must only be made while the block is idle.
module square_doubling_pop_order_sorter
#(
    parameter int MAX_ITEMS = sdpos_pkg::MAX_ITEMS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    sdpos_item_if.sink                        item_ch,
    sdpos_result_if.source                    result_ch,
    input  logic                              cfg_we,
    input  logic [sdpos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdpos_pkg::THR_W-1:0]       cfg_data
);

    logic [sdpos_pkg::THR_W-1:0]    threshold_reg;
    logic [sdpos_pkg::LIMIT_W-1:0]  limit_reg;

    logic                           q_push;
    sdpos_pkg::item_t               q_push_item;
    logic                           q_full;
    logic                           q_pop;
    logic                           q_empty;
    sdpos_pkg::item_t               q_pop_item;
    logic                           res_valid;
    sdpos_pkg::result_t             res;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= sdpos_pkg::THR_RESET;
            limit_reg     <= sdpos_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdpos_pkg::CFG_POP_THRESHOLD: threshold_reg <= cfg_data;
                sdpos_pkg::CFG_ROUND_LIMIT:   limit_reg     <= cfg_data[sdpos_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    // Classify each request: square it and find its natural pop round.
    sdpos_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_ch.valid),
        .in_ready  (item_ch.ready),
        .in_value  (item_ch.item_value),
        .in_end    (item_ch.batch_end),
        .threshold (threshold_reg),
        .push      (q_push),
        .push_item (q_push_item),
        .q_full    (q_full)
    );

    // Decouple classification from the batch sweep.
    sdpos_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_pop_item)
    );

    // Store the batch, then emit the popped values in round order.
    sdpos_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_pop_item),
        .q_pop       (q_pop),
        .round_limit (limit_reg),
        .res_valid   (res_valid),
        .res_ready   (result_ch.ready),
        .res         (res)
    );

    assign result_ch.valid        = res_valid;
    assign result_ch.out_value    = res.value;
    assign result_ch.out_position = res.position;
    assign result_ch.out_valid    = res.present;
    assign result_ch.out_last     = res.last;
    assign result_ch.out_dropped  = res.dropped;

endmodule

// ===== src/sdpos_checker.sv =====
// Port-level checks for the pop-order sorter, attached to the top level by bind.
// Depends on sdpos_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdpos_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic [sdpos_pkg::VALUE_W-1:0]   res_value,
    input  logic [sdpos_pkg::POS_W-1:0]     res_position,
    input  logic                            res_present,
    input  logic                            res_last,
    input  logic                            res_dropped
);

    // Hold no result while in reset.
    `SDPOS_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !res_valid, "result during reset")

    // Hold a stalled result unchanged.
    `SDPOS_ASSERT_RUN(a_stall_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable({res_value, res_position, res_present, res_last, res_dropped}), "stalled result changed")

    // An empty-batch result closes the batch and carries no item.
    `SDPOS_ASSERT_RUN(a_empty_shape, clk, rst_n, res_valid && !res_present |-> res_last && (res_position == '0) && (res_value == '0), "malformed empty result")

    // Positions past the first come only with a popped item.
    `SDPOS_ASSERT_RUN(a_pos_needs_item, clk, rst_n, res_valid && (res_position != '0) |-> res_present, "position without item")

endmodule

bind square_doubling_pop_order_sorter sdpos_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .res_value    (result_ch.out_value),
    .res_position (result_ch.out_position),
    .res_present  (result_ch.out_valid),
    .res_last     (result_ch.out_last),
    .res_dropped  (result_ch.out_dropped)
);
